// ===== hw/rtl/smoothed_meter_needle_angle_defines.svh =====
// Assertion shorthands shared by the meter needle RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef SMOOTHED_METER_NEEDLE_ANGLE_DEFINES_SVH
`define SMOOTHED_METER_NEEDLE_ANGLE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define SMNA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SMNA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMNA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/smna_pkg.sv =====
`timescale 1ns / 1ps
package smna_pkg;

   localparam int unsigned HALF_W          = 16;
   localparam int unsigned LEVEL_W         = 24;
   localparam int unsigned PAD_W           = LEVEL_W - HALF_W;
   localparam int unsigned ALPHA_W         = 17;
   localparam int unsigned FRAC_W          = 16;
   localparam int unsigned PROD_W          = LEVEL_W + 1 + ALPHA_W;
   localparam int unsigned COUNT_W         = 4;
   localparam int unsigned CSR_IDX_W       = 3;
   localparam int unsigned CSR_DATA_W      = 64;
   localparam int unsigned HALVES_PER_WORD = 4;
   localparam int unsigned QUOT_W          = 16;
   localparam int unsigned STEP_W          = $clog2(QUOT_W);
   // depth must stay a power of two: pointers wrap naturally
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA       = 3'd0,
      CSR_POINT_COUNT = 3'd1,
      CSR_LEVELS_LO   = 3'd2,
      CSR_LEVELS_HI   = 3'd3,
      CSR_ANGLES_LO   = 3'd4,
      CSR_ANGLES_HI   = 3'd5
   } csr_index_type;

   typedef logic signed [HALF_W-1:0] half_type;

   typedef struct packed {
      half_type db;
      logic     changed;
   } smna_item_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_FIRST,
      B_LAST,
      B_SCAN,
      B_MUL,
      B_DIV,
      B_ADD,
      B_OUT
   } back_state_type;

endpackage

// ===== hw/rtl/smna_channels.sv =====
`timescale 1ns / 1ps
interface smna_req_if
   import smna_pkg::*;
();
   logic     valid;
   logic     ready;
   half_type target_db;
   logic     snap;

   modport source (output valid, output target_db, output snap, input ready);
   modport sink   (input valid, input target_db, input snap, output ready);
endinterface

interface smna_rsp_if
   import smna_pkg::*;
();
   logic     valid;
   logic     ready;
   half_type smoothed_db;
   half_type angle_deg;
   logic     changed;

   modport source (output valid, output smoothed_db, output angle_deg, output changed,
                   input ready);
   modport sink   (input valid, input smoothed_db, input angle_deg, input changed,
                   output ready);
endinterface

// ===== hw/rtl/smoothed_meter_needle_angle.sv =====
`timescale 1ns / 1ps
// Meter needle: smooth a target dB level and map it to a needle angle.
// req_bus carries one word per meter tick (target_db Q8.8, snap); rsp_bus
// returns one word per tick (smoothed_db Q8.8, angle_deg Q10.6, changed).
// Both are valid/ready channels; a word moves when valid and ready are high.
// The csr_ port writes one register per cycle when csr_we is high; write it
// only while no tick is in flight.
// The front end takes a tick, multiplies by alpha, and hands the new level
// to a two-word queue; it takes no new tick until that level is pushed.
// The back end interpolates: clamped or empty tables skip the breakpoint
// scan, while an interpolated tick scans the breakpoints and then runs the
// 16-step restoring divider.
// While rsp_bus stalls, the back end holds its result and the front end keeps
// taking ticks until the queue fills, then drops req_bus.ready.
// Synchronous reset clears the level to zero, alpha to one (follow at once),
// the point count and all breakpoints to zero, and empties the queue.
module smoothed_meter_needle_angle
   import smna_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   smna_req_if.sink              req_bus,
   smna_rsp_if.source            rsp_bus
);

   // points reachable from the first packed word
   localparam int unsigned LO_POINTS =
      (MAX_POINTS < HALVES_PER_WORD) ? MAX_POINTS : HALVES_PER_WORD;

   logic [ALPHA_W-1:0] alpha_ff;
   logic [COUNT_W-1:0] point_count_ff;
   half_type           level_ff [MAX_POINTS];
   half_type           angle_ff [MAX_POINTS];

   logic               push_valid;
   logic               push_ready;
   smna_item_type      push_item;
   logic               pop_valid;
   logic               pop_ready;
   smna_item_type      pop_item;

   // register file: unpack each 64-bit table word into four breakpoint halves,
   // drop halves beyond the table, ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff       <= ALPHA_ONE;
         point_count_ff <= '0;
         for (int p = 0; p < MAX_POINTS; p++) begin
            level_ff[p] <= '0;
            angle_ff[p] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: begin
               alpha_ff <= csr_wdata[ALPHA_W-1:0];
            end
            CSR_POINT_COUNT: begin
               point_count_ff <= csr_wdata[COUNT_W-1:0];
            end
            CSR_LEVELS_LO: begin
               for (int p = 0; p < LO_POINTS; p++)
                  level_ff[p] <= csr_wdata[p*HALF_W +: HALF_W];
            end
            CSR_LEVELS_HI: begin
               for (int p = HALVES_PER_WORD; p < MAX_POINTS; p++)
                  level_ff[p] <= csr_wdata[(p-HALVES_PER_WORD)*HALF_W +: HALF_W];
            end
            CSR_ANGLES_LO: begin
               for (int p = 0; p < LO_POINTS; p++)
                  angle_ff[p] <= csr_wdata[p*HALF_W +: HALF_W];
            end
            CSR_ANGLES_HI: begin
               for (int p = HALVES_PER_WORD; p < MAX_POINTS; p++)
                  angle_ff[p] <= csr_wdata[(p-HALVES_PER_WORD)*HALF_W +: HALF_W];
            end
            default: ;
         endcase
      end
   end

   // front end: accept the tick and advance the smoothed level
   smna_front u_front (
      .clock      (clock),
      .reset      (reset),
      .alpha      (alpha_ff),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // short queue: lets the front end run ahead while the mapping is busy
   smna_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // back end: clamp, scan breakpoints, interpolate, hold the response
   smna_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .point_count (point_count_ff),
      .levels      (level_ff),
      .angles      (angle_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .rsp_bus     (rsp_bus)
   );

endmodule

// ===== hw/rtl/smna_front.sv =====
`timescale 1ns / 1ps
`include "smoothed_meter_needle_angle_defines.svh"
module smna_front
   import smna_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ALPHA_W-1:0] alpha,
   smna_req_if.sink           req_bus,
   output logic               push_valid,
   input  logic               push_ready,
   output smna_item_type      push_item
);

   front_state_type state_ff, state_in;

   half_type                  tgt_ff;
   logic                      snap_ff;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic signed [LEVEL_W:0]   diff;
   logic signed [ALPHA_W-1:0] weight;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      accept;
   logic                      push_fire;
   logic                      follow;

   assign accept    = req_bus.valid && req_bus.ready;
   assign push_fire = push_valid && push_ready;

   // snap, or alpha at or above one, copies the target
   assign follow = snap_ff || alpha[ALPHA_W-1];
   assign weight = $signed({1'b0, alpha[FRAC_W-1:0]});
   assign diff   = $signed({tgt_ff[HALF_W-1], tgt_ff, {PAD_W{1'b0}}})
                 - $signed({level_ff[LEVEL_W-1], level_ff});

   // arithmetic shift of the product floors the step
   always_comb begin
      if (follow) begin
         level_in = $signed({tgt_ff, {PAD_W{1'b0}}});
      end else begin
         level_in = level_ff + $signed(prod_ff[FRAC_W +: LEVEL_W]);
      end
   end

   assign push_item.db      = level_in[LEVEL_W-1 -: HALF_W];
   assign push_item.changed = (level_in != level_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_MUL;
         end
         F_MUL: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      push_valid    = 1'b0;
      case (state_ff)
         F_IDLE:  req_bus.ready = 1'b1;
         F_PUSH:  push_valid    = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (push_fire) level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tgt_ff  <= req_bus.target_db;
         snap_ff <= req_bus.snap;
      end
      if (state_ff == F_MUL) prod_ff <= diff * weight;
   end

   `SMNA_ASSERT_NEXT(a_level_holds, !push_fire, $stable(level_ff), "level moved without push")

endmodule

// ===== hw/rtl/smna_queue.sv =====
`timescale 1ns / 1ps
`include "smoothed_meter_needle_angle_defines.svh"
module smna_queue
   import smna_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  smna_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output smna_item_type pop_item
);

   smna_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_fire) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop_fire)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) slot_ff[wr_ptr_ff] <= push_item;
   end

   `SMNA_ASSERT_ALWAYS(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `SMNA_ASSERT_NEXT(a_push_visible, (count_ff == '0) && push_fire, pop_valid, "pushed word lost")

endmodule

// ===== hw/rtl/smna_back.sv =====
`timescale 1ns / 1ps
`include "smoothed_meter_needle_angle_defines.svh"
module smna_back
   import smna_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] point_count,
   input  half_type           levels [MAX_POINTS],
   input  half_type           angles [MAX_POINTS],
   input  logic               pop_valid,
   output logic               pop_ready,
   input  smna_item_type      pop_item,
   smna_rsp_if.source         rsp_bus
);

   localparam int unsigned IDX_W = $clog2(MAX_POINTS);
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

   back_state_type state_ff, state_in;

   half_type           db_ff;
   logic               changed_ff;
   half_type           res_ff;
   half_type           lo_level_ff;
   half_type           lo_angle_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [HALF_W-1:0]  dl_ff;
   logic [HALF_W-1:0]  span_ff;
   logic signed [HALF_W:0] da_ff;
   logic [HALF_W-1:0]  rem_ff;
   logic [HALF_W-1:0]  quo_ff;
   logic               neg_ff;
   logic [STEP_W-1:0]  step_ff;

   logic [CNT_W-1:0]   n_eff;
   logic [IDX_W-1:0]   last_idx;
   logic [IDX_W-1:0]   rd_addr;
   half_type           rd_level;
   half_type           rd_angle;
   logic               db_le;
   logic               db_ge;
   logic               none;
   logic               pop_fire;
   logic               div_last;
   logic               take;
   logic signed [HALF_W:0] lo_gap;
   logic signed [HALF_W:0] level_gap;
   logic signed [HALF_W:0] angle_gap;
   logic [HALF_W:0]    angle_mag;
   logic [2*HALF_W-1:0] prod;
   logic [HALF_W+1:0]  trial;
   logic [HALF_W-1:0]  shifted;
   logic signed [HALF_W:0] q_signed;
   logic signed [HALF_W:0] angle_sum;

   // clamp the point count to the table size
   always_comb begin
      if (point_count > COUNT_W'(MAX_POINTS)) n_eff = CNT_W'(MAX_POINTS);
      else                                    n_eff = point_count[CNT_W-1:0];
   end

   assign last_idx = IDX_W'(n_eff - 1'b1);
   assign none     = (n_eff == '0);
   assign rd_level = levels[rd_addr];
   assign rd_angle = angles[rd_addr];
   assign db_le    = ($signed(db_ff) <= $signed(rd_level));
   assign db_ge    = ($signed(db_ff) >= $signed(rd_level));
   assign pop_fire = pop_valid && pop_ready;
   assign div_last = (step_ff == STEP_W'(QUOT_W - 1));

   assign lo_gap    = $signed({db_ff[HALF_W-1], db_ff})
                    - $signed({lo_level_ff[HALF_W-1], lo_level_ff});
   assign level_gap = $signed({rd_level[HALF_W-1], rd_level})
                    - $signed({lo_level_ff[HALF_W-1], lo_level_ff});
   assign angle_gap = $signed({rd_angle[HALF_W-1], rd_angle})
                    - $signed({lo_angle_ff[HALF_W-1], lo_angle_ff});

   // divide the magnitude, restore the sign afterwards (truncates toward zero)
   assign angle_mag = da_ff[HALF_W] ? (HALF_W+1)'(-da_ff) : da_ff;
   assign prod      = dl_ff * angle_mag[HALF_W-1:0];
   assign trial     = {1'b0, rem_ff, quo_ff[HALF_W-1]} - {2'b00, span_ff};
   assign take      = !trial[HALF_W+1];
   assign shifted   = {rem_ff[HALF_W-2:0], quo_ff[HALF_W-1]};
   assign q_signed  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign angle_sum = $signed({lo_angle_ff[HALF_W-1], lo_angle_ff}) + q_signed;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) state_in = B_FIRST;
         end
         B_FIRST: begin
            if (none || db_le) state_in = B_OUT;
            else               state_in = B_LAST;
         end
         B_LAST: begin
            if (db_ge) state_in = B_OUT;
            else       state_in = B_SCAN;
         end
         B_SCAN: begin
            if (db_le) state_in = B_MUL;
         end
         B_MUL: begin
            state_in = B_DIV;
         end
         B_DIV: begin
            if (div_last) state_in = B_ADD;
         end
         B_ADD: begin
            state_in = B_OUT;
         end
         B_OUT: begin
            if (rsp_bus.ready) state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      pop_ready     = 1'b0;
      rsp_bus.valid = 1'b0;
      rd_addr       = idx_ff;
      case (state_ff)
         B_IDLE:  pop_ready     = 1'b1;
         B_FIRST: rd_addr       = IDX_W'(0);
         B_LAST:  rd_addr       = last_idx;
         B_OUT:   rsp_bus.valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_bus.smoothed_db = db_ff;
   assign rsp_bus.angle_deg   = res_ff;
   assign rsp_bus.changed     = changed_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (pop_fire) begin
               db_ff      <= pop_item.db;
               changed_ff <= pop_item.changed;
            end
         end
         B_FIRST: begin
            if (none)       res_ff <= '0;
            else if (db_le) res_ff <= rd_angle;
            lo_level_ff <= rd_level;
            lo_angle_ff <= rd_angle;
            idx_ff      <= IDX_W'(1);
         end
         B_LAST: begin
            if (db_ge) res_ff <= rd_angle;
         end
         B_SCAN: begin
            if (db_le) begin
               dl_ff   <= lo_gap[HALF_W-1:0];
               span_ff <= level_gap[HALF_W-1:0];
               da_ff   <= angle_gap;
            end else begin
               lo_level_ff <= rd_level;
               lo_angle_ff <= rd_angle;
               idx_ff      <= idx_ff + 1'b1;
            end
         end
         B_MUL: begin
            rem_ff  <= prod[2*HALF_W-1:HALF_W];
            quo_ff  <= prod[HALF_W-1:0];
            neg_ff  <= da_ff[HALF_W];
            step_ff <= '0;
         end
         B_DIV: begin
            rem_ff  <= take ? trial[HALF_W-1:0] : shifted;
            quo_ff  <= {quo_ff[HALF_W-2:0], take};
            step_ff <= step_ff + 1'b1;
         end
         B_ADD: begin
            res_ff <= angle_sum[HALF_W-1:0];
         end
         default: ;
      endcase
   end

   `SMNA_ASSERT_SAME(a_rem_below_span, state_ff == B_DIV, rem_ff < span_ff, "remainder not below span")

endmodule
